[hw/rtl/rsfm_pkg.sv]
// shared types and constants for the rs485 frame matcher
package rsfm_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 6;
    localparam int OUT_W  = 16;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [LEN_W-1:0]  len_t;

    localparam byte_t HDR_FIRST  = 8'h0A;
    localparam byte_t HDR_SECOND = 8'h0D;

    localparam len_t MIN_FRAME = 6'd5;
    localparam len_t LEN_RESET = 6'd30;

    // configuration register indexes
    localparam logic REG_STATION = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    // control between the matching front and the emitting back
    typedef struct packed {
        logic valid;
        len_t len;
    } slot_ctrl_t;

endpackage

[hw/rtl/rsfm_front.sv]
// front: sliding byte window, frame match and one-frame hand-off slot
module rsfm_front #(
    parameter int MAX_FRAME = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rsfm_pkg::byte_t     rx_byte,
    input  rsfm_pkg::byte_t     station,
    input  rsfm_pkg::len_t      frame_length,
    output rsfm_pkg::slot_ctrl_t slot_ctrl,
    output rsfm_pkg::byte_t     slot_data [(MAX_FRAME < 32 ? MAX_FRAME : 32)],
    input  logic                slot_ready
);

    localparam int CAP = (MAX_FRAME < 32) ? MAX_FRAME : 32;
    localparam int WIW = $clog2(MAX_FRAME);

    rsfm_pkg::byte_t win_reg  [MAX_FRAME];
    rsfm_pkg::byte_t win_next [MAX_FRAME];
    rsfm_pkg::byte_t slot_data_reg [CAP];
    rsfm_pkg::len_t  slot_len_reg;
    logic            slot_valid_reg;
    rsfm_pkg::len_t  fill_reg;
    rsfm_pkg::len_t  fill_next;
    rsfm_pkg::len_t  eff_len;
    logic [WIW-1:0]  base;
    logic [MAX_FRAME-1:0] hdr_ok;
    logic            accept;
    logic            match;

    assign s_tready = !slot_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < MAX_FRAME - 1; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[MAX_FRAME-1] = rx_byte;
    end

    // header test at each window position with room for the header, picked by the frame length below
    always_comb begin
        for (int i = 0; i < MAX_FRAME; i++) begin
            if (i + 2 < MAX_FRAME) begin
                hdr_ok[i] = (win_next[i] == rsfm_pkg::HDR_FIRST)
                         && (win_next[i+1] == rsfm_pkg::HDR_SECOND)
                         && (win_next[i+2] == station);
            end else begin
                hdr_ok[i] = 1'b0;
            end
        end
    end

    always_comb begin
        if (frame_length < rsfm_pkg::MIN_FRAME) begin
            eff_len = rsfm_pkg::MIN_FRAME;
        end else if (frame_length > rsfm_pkg::LEN_W'(CAP)) begin
            eff_len = rsfm_pkg::LEN_W'(CAP);
        end else begin
            eff_len = frame_length;
        end
    end

    assign base      = WIW'(32'(MAX_FRAME) - 32'(eff_len));
    assign fill_next = (fill_reg < rsfm_pkg::LEN_W'(CAP)) ? fill_reg + 6'd1 : fill_reg;
    assign match     = (fill_next >= eff_len) && hdr_ok[base]
                    && (win_reg[MAX_FRAME-1] == rsfm_pkg::HDR_SECOND)
                    && (rx_byte == rsfm_pkg::HDR_FIRST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            slot_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg <= match ? '0 : fill_next;
            end
            if (accept && match) begin
                slot_valid_reg <= 1'b1;
            end else if (slot_ready) begin
                slot_valid_reg <= 1'b0;
            end
        end
    end

    // window needs no clearing: the fill count keeps stale bytes out of a match
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
            if (match) begin
                slot_len_reg <= eff_len;
                for (int j = 0; j < CAP; j++) begin
                    slot_data_reg[j] <= win_next[MAX_FRAME-CAP+j];
                end
            end
        end
    end

    assign slot_ctrl.valid = slot_valid_reg;
    assign slot_ctrl.len   = slot_len_reg;
    assign slot_data       = slot_data_reg;

endmodule

[hw/rtl/rsfm_back.sv]
// back: takes a matched frame from the slot and streams its bytes out
module rsfm_back #(
    parameter int MAX_FRAME = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rsfm_pkg::slot_ctrl_t slot_ctrl,
    input  rsfm_pkg::byte_t      slot_data [(MAX_FRAME < 32 ? MAX_FRAME : 32)],
    output logic                 slot_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output rsfm_pkg::byte_t      frame_byte,
    output rsfm_pkg::pos_t       byte_position,
    output logic                 last_of_frame
);

    localparam int CAP = (MAX_FRAME < 32) ? MAX_FRAME : 32;
    localparam int IW  = $clog2(CAP);

    rsfm_pkg::byte_t buf_reg [CAP];
    logic [IW-1:0]   start_reg;
    rsfm_pkg::pos_t  pos_reg;
    rsfm_pkg::len_t  len_reg;
    logic            busy_reg;
    logic            out_valid_reg;
    rsfm_pkg::byte_t out_byte_reg;
    rsfm_pkg::pos_t  out_pos_reg;
    logic            out_last_reg;
    logic [IW-1:0]   rd_idx;
    logic            load_out;
    logic            at_last;
    logic            take;

    assign slot_ready = !busy_reg;
    assign take       = slot_ctrl.valid && !busy_reg;
    assign load_out   = busy_reg && (!out_valid_reg || m_tready);
    assign rd_idx     = start_reg + IW'(pos_reg);
    assign at_last    = (rsfm_pkg::LEN_W'(pos_reg) + 6'd1) == len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                busy_reg <= 1'b1;
            end else if (load_out && at_last) begin
                busy_reg <= 1'b0;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            buf_reg   <= slot_data;
            len_reg   <= slot_ctrl.len;
            start_reg <= IW'(32'(CAP) - 32'(slot_ctrl.len));
            pos_reg   <= '0;
        end else if (load_out) begin
            pos_reg <= pos_reg + 5'd1;
        end
        if (load_out) begin
            out_byte_reg <= buf_reg[rd_idx];
            out_pos_reg  <= pos_reg;
            out_last_reg <= at_last;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign frame_byte    = out_byte_reg;
    assign byte_position = out_pos_reg;
    assign last_of_frame = out_last_reg;

endmodule

[hw/rtl/rs485_frame_matcher.sv]
// top level: configuration registers, matching front and emitting back
// first frame byte goes via the hand-off slot, back frame buffer and output register
// one byte per cycle in while s_tready is high; the back streams one frame at a time
// s_tready drops while the hand-off slot holds a frame the back has not taken
// the slot frees when the back starts a frame, so a second frame may wait there
// reset: synchronous on aresetn, clears control and config; window not cleared
module rs485_frame_matcher #(
    parameter int MAX_FRAME = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] frame_byte, [12:8] byte_position, zero fill
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int CAP = (MAX_FRAME < 32) ? MAX_FRAME : 32;

    rsfm_pkg::byte_t      station_reg;
    rsfm_pkg::len_t       length_reg;
    rsfm_pkg::slot_ctrl_t slot_ctrl;
    rsfm_pkg::byte_t      slot_data [CAP];
    logic                 slot_ready;
    rsfm_pkg::byte_t      frame_byte;
    rsfm_pkg::pos_t       byte_position;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_reg <= '0;
            length_reg  <= rsfm_pkg::LEN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                rsfm_pkg::REG_STATION: station_reg <= cfg_wdata;
                rsfm_pkg::REG_LENGTH:  length_reg  <= cfg_wdata[rsfm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    rsfm_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .rx_byte      (s_tdata),
        .station      (station_reg),
        .frame_length (length_reg),
        .slot_ctrl    (slot_ctrl),
        .slot_data    (slot_data),
        .slot_ready   (slot_ready)
    );

    rsfm_back #(.MAX_FRAME(MAX_FRAME)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .slot_ctrl     (slot_ctrl),
        .slot_data     (slot_data),
        .slot_ready    (slot_ready),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last_of_frame (m_tlast)
    );

    assign m_tdata = {3'b000, byte_position, frame_byte};

endmodule

[hw/rtl/rsfm_checker.sv]
// checker on the frame matcher ports, bound to the top level
module rsfm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    // a frame opens with the header pair
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[12:8] == 5'd0) |-> m_tdata[7:0] == rsfm_pkg::HDR_FIRST)
        else $error("frame does not open with 0x0A");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[12:8] == 5'd1)
            |-> m_tdata[7:0] == rsfm_pkg::HDR_SECOND && !m_tlast)
        else $error("second frame byte is not 0x0D");

    // a frame closes with 0x0A and is never shorter than the minimum
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[7:0] == rsfm_pkg::HDR_FIRST && m_tdata[12:8] >= 5'd4)
        else $error("bad frame end");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind rs485_frame_matcher rsfm_checker u_rsfm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
